@@ hw/rtl/ievwa_pkg.sv @@
// Package for the interval event window accumulator.
// Action and status codes, sequencer states and fixed field widths.
// No dependencies.
package ievwa_pkg;

  localparam int ACT_W = 3;
  localparam int AMT_W = 32;
  localparam int VAL_W = 48;
  localparam int STS_W = 2;

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUM    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RECENT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_EXPIRE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRUNE  = 3'd4;

  localparam logic [STS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL = 2'd1;
  localparam logic [STS_W-1:0] STS_SAT  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_EV   = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_DVS  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

@@ hw/rtl/ievwa_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Uses ievwa_pkg only for house consistency of types; standalone otherwise.
module ievwa_div
  import ievwa_pkg::*;
#(
  parameter int NW = 80,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    nq;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dr;
  logic [DW:0]      rs;
  logic [DW:0]      diff;
  logic             qbit;

  // shift in next numerator bit, trial subtract
  always_comb begin
    rs   = {rem, nq[NW-1]};
    diff = rs - {1'b0, dr};
    qbit = (rs >= {1'b0, dr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits fill nq from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
      dr  <= den;
    end else if (busy) begin
      nq  <= {nq[NW-2:0], qbit};
      rem <= qbit ? diff[DW-1:0] : rs[DW-1:0];
    end
  end

  assign quo = nq;

endmodule

@@ hw/rtl/interval_event_window_accumulator.sv @@
// Top level of the interval event window accumulator: event table memory,
// scan sequencer, multiply-accumulate and output register.
// Depends on ievwa_pkg and ievwa_div.
//
//  channel | dir | tvalid/tready | payload
//  s_      | in  | s_tvalid/s_tready | tuser action, tdata time_a,time_b,amount_in
//  m_      | out | m_tvalid/m_tready | tdata value_out,status
//
// One transfer in gives one transfer out. The table sits in one memory with a
// registered read; each scanned entry is read (S_RD) and then evaluated (S_EV),
// and a window sum adds a multiply-accumulate step (S_ACC) per entry before the
// divider works out SW = TIME_BITS+33+log2(depth)+1 quotient bits. Recent and
// expire scan the table once, prune twice (search, then compaction). Reset
// clears the count, the sequencer state and the handshake only. Input is taken
// whenever the sequencer is idle, even while a result waits for m_tready.
module interval_event_window_accumulator
  import ievwa_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 40
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // time_a, time_b, amount_in (lowest first), zero padded
  input  logic [((2*TIME_BITS+AMT_W+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [ACT_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // value_out, status (lowest first), zero padded
  output logic [((VAL_W+STS_W+7)/8)*8-1:0] m_tdata
);

  localparam int TB   = TIME_BITS;
  localparam int OUTW = ((VAL_W+STS_W+7)/8)*8;
  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int MW   = 2*TB + AMT_W;
  localparam int PW   = TB + AMT_W + 1;
  localparam int SW   = PW + IW + 1;

  state_t state;

  logic [ACT_W-1:0] op;
  logic [TB-1:0]    ta, tb;
  logic [CW-1:0]    count, n;
  logic [IW-1:0]    idx, cur;
  logic             pass;
  logic [TB-1:0]    cs;
  logic [AMT_W-1:0] ca;
  logic signed [SW-1:0] acc;
  logic signed [PW-1:0] prod;
  logic             negr;
  logic [VAL_W-1:0] val;
  logic [STS_W-1:0] st;

  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_q;
  logic          we;
  logic [IW-1:0] wa;
  logic [MW-1:0] wd;

  logic s_xfer;
  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;

  // incoming fields
  logic [TB-1:0]    in_ta, in_tb;
  logic [AMT_W-1:0] in_amt;
  logic [TB:0]      end_sum;
  logic [TB-1:0]    in_end;
  assign in_ta   = s_tdata[TB-1:0];
  assign in_tb   = s_tdata[2*TB-1:TB];
  assign in_amt  = s_tdata[2*TB+AMT_W-1:2*TB];
  assign end_sum = {1'b0, in_ta} + {1'b0, in_tb};
  assign in_end  = end_sum[TB] ? {TB{1'b1}} : end_sum[TB-1:0];

  // entry fields and per-entry decisions
  logic [TB-1:0]    rs, re, ov_lo, ov_hi, ovl;
  logic [AMT_W-1:0] ram;
  logic             hit, first, better, keep, last_up, compact;
  logic signed [PW-1:0] prod_c;
  logic [AMT_W-1:0] ca_new;
  logic [CW-1:0]    cnt_m1;

  always_comb begin
    rs      = rd_q[TB-1:0];
    re      = rd_q[2*TB-1:TB];
    ram     = rd_q[MW-1:2*TB];
    cnt_m1  = count - CW'(1);
    last_up = (CW'(idx) == cnt_m1);
    first   = last_up && !pass;
    hit     = (ta >= rs) && (ta <= re);
    better  = first || (hit && (cs < rs));
    ca_new  = better ? ram : ca;
    ov_lo   = (rs > ta) ? rs : ta;
    ov_hi   = (re < tb) ? re : tb;
    ovl     = ((ta < re) && (rs < tb)) ? (ov_hi - ov_lo) : '0;
    prod_c  = $signed(ram) * $signed({1'b0, ovl});
    compact = (op == ACT_EXPIRE) || pass;
    keep    = (op == ACT_EXPIRE) ? !(ta > re) : ((idx == cur) || (rs >= ta));
  end

  // memory write selection
  always_comb begin
    we = 1'b0;
    wa = n[IW-1:0];
    wd = rd_q;
    if (s_xfer && (s_tuser == ACT_ADD) && (count < CW'(TABLE_DEPTH))) begin
      we = 1'b1;
      wa = count[IW-1:0];
      wd = {in_amt, in_end, in_ta};
    end else if ((state == S_EV) && (op != ACT_SUM) && compact && keep) begin
      we = 1'b1;
    end
  end

  // event table
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[idx];
  end

  // divider
  logic            div_start, div_busy, div_done;
  logic [SW-1:0]   div_num, quo;
  logic [TB-1:0]   div_den;
  assign div_start = (state == S_DVS);
  assign div_num   = acc[SW-1] ? SW'(-acc) : SW'(acc);
  assign div_den   = tb - ta;

  ievwa_div #(.NW(SW), .DW(TB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // saturation of the quotient
  localparam logic [SW-1:0] QPOS = SW'({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic [SW-1:0] QNEG = SW'({1'b1, {(VAL_W-1){1'b0}}});
  logic             q_sat;
  logic [VAL_W-1:0] q_val;
  always_comb begin
    q_sat = negr ? (quo > QNEG) : (quo > QPOS);
    if (negr) begin
      q_val = q_sat ? QNEG[VAL_W-1:0] : VAL_W'(-quo[VAL_W-1:0]);
    end else begin
      q_val = q_sat ? QPOS[VAL_W-1:0] : quo[VAL_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_xfer) begin
            op   <= s_tuser;
            ta   <= in_ta;
            tb   <= in_tb;
            acc  <= '0;
            n    <= '0;
            pass <= 1'b0;
            val  <= '0;
            st   <= STS_OK;
            state <= S_OUT;
            case (s_tuser)
              ACT_ADD: begin
                if (count < CW'(TABLE_DEPTH)) begin
                  count <= count + CW'(1);
                end else begin
                  st <= STS_FULL;
                end
              end
              ACT_SUM: begin
                idx <= '0;
                if (in_tb > in_ta) begin
                  state <= (count == '0) ? S_DVS : S_RD;
                end
              end
              ACT_RECENT, ACT_PRUNE: begin
                idx <= IW'(count - CW'(1));
                if (count != '0) begin
                  state <= S_RD;
                end
              end
              ACT_EXPIRE: begin
                idx <= '0;
                if (count != '0) begin
                  state <= S_RD;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          state <= S_RD;
          if (op == ACT_SUM) begin
            prod  <= prod_c;
            state <= S_ACC;
          end else if (compact) begin
            if (keep) begin
              n <= n + CW'(1);
            end
            if (last_up) begin
              count <= keep ? n + CW'(1) : n;
              state <= S_OUT;
            end else begin
              idx <= idx + IW'(1);
            end
          end else begin
            // recent search, newest to oldest
            if (better) begin
              cur <= idx;
              cs  <= rs;
              ca  <= ram;
            end
            if (idx == '0) begin
              if (op == ACT_RECENT) begin
                val   <= {{(VAL_W-AMT_W){ca_new[AMT_W-1]}}, ca_new};
                state <= S_OUT;
              end else begin
                pass <= 1'b1;
              end
            end else begin
              idx <= idx - IW'(1);
            end
          end
        end
        S_ACC: begin
          acc <= acc + SW'(prod);
          if (last_up) begin
            state <= S_DVS;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_RD;
          end
        end
        S_DVS: begin
          negr  <= acc[SW-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            val   <= q_val;
            st    <= q_sat ? STS_SAT : STS_OK;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUTW'({st, val});
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("event count above table depth");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EV) && we) |-> (CW'(idx) >= n))
    else $error("compaction write overtakes read pointer");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result raised outside output state");

endmodule

@@ tb/tb_ievwa_checker.sv @@
// Checker for the interval event window accumulator: watches both stream
// channels, predicts each result from its own event table and compares.
// Depends on ievwa_pkg.
module tb_ievwa_checker
  import ievwa_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [111:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [STS_W-1:0] status;
  } result_t;

  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic signed [127:0] POS_LIM = (128'sd1 <<< 47) - 1;
  localparam logic signed [127:0] NEG_LIM = -(128'sd1 <<< 47);

  logic [TIME_BITS-1:0] ev_start [TABLE_DEPTH];
  logic [TIME_BITS-1:0] ev_end   [TABLE_DEPTH];
  logic signed [31:0]   ev_amt   [TABLE_DEPTH];
  int                   ev_count;
  result_t              expected_results [$];

  // newest-first search: start at the newest event, move to a containing event with a later start
  function automatic int recent_slot(logic [TIME_BITS-1:0] t);
    int cur;
    cur = ev_count - 1;
    for (int i = ev_count - 1; i >= 0; i--)
      if (t >= ev_start[i] && t <= ev_end[i] && ev_start[cur] < ev_start[i]) cur = i;
    return cur;
  endfunction

  function automatic result_t apply_item(logic [2:0] act, logic [TIME_BITS-1:0] ta,
                                         logic [TIME_BITS-1:0] tb, logic signed [31:0] amt);
    result_t r;
    logic [TIME_BITS:0] e;
    logic signed [127:0] acc, q, lo, hi;
    int n, cur;
    r = '0;
    case (act)
      ACT_ADD: begin
        if (ev_count >= TABLE_DEPTH) r.status = STS_FULL;
        else begin
          e = {1'b0, ta} + {1'b0, tb};
          ev_start[ev_count] = ta;
          ev_end[ev_count] = e[TIME_BITS] ? TMAX : e[TIME_BITS-1:0];
          ev_amt[ev_count] = amt;
          ev_count++;
        end
      end
      ACT_SUM: begin
        if (tb > ta) begin
          acc = 0;
          for (int i = 0; i < ev_count; i++)
            if (ta < ev_end[i] && ev_start[i] < tb) begin
              lo = (ev_start[i] > ta) ? ev_start[i] : ta;
              hi = (ev_end[i] < tb) ? ev_end[i] : tb;
              acc += 128'(signed'(ev_amt[i])) * (hi - lo);
            end
          q = acc / $signed({88'd0, tb - ta});
          if (q > POS_LIM) begin q = POS_LIM; r.status = STS_SAT; end
          else if (q < NEG_LIM) begin q = NEG_LIM; r.status = STS_SAT; end
          r.value = q[VAL_W-1:0];
        end
      end
      ACT_RECENT: if (ev_count > 0) r.value = VAL_W'(ev_amt[recent_slot(ta)]);
      ACT_EXPIRE: begin
        n = 0;
        for (int i = 0; i < ev_count; i++)
          if (!(ta > ev_end[i])) begin
            ev_start[n] = ev_start[i]; ev_end[n] = ev_end[i]; ev_amt[n] = ev_amt[i]; n++;
          end
        ev_count = n;
      end
      ACT_PRUNE: if (ev_count > 0) begin
        cur = recent_slot(ta);
        n = 0;
        for (int i = 0; i < ev_count; i++)
          if (i == cur || ev_start[i] >= ta) begin
            ev_start[n] = ev_start[i]; ev_end[n] = ev_end[i]; ev_amt[n] = ev_amt[i]; n++;
          end
        ev_count = n;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  // sample on the edge; drivers update with nonblocking assignments
  always @(posedge clk) begin
    result_t got, want, nxt;
    if (rst) begin
      ev_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        nxt = apply_item(s_tuser, s_tdata[TIME_BITS-1:0],
                         s_tdata[2*TIME_BITS-1:TIME_BITS],
                         s_tdata[2*TIME_BITS+31:2*TIME_BITS]);
        expected_results = {expected_results, nxt};
      end
      if (m_tvalid && m_tready) begin
        got.value = m_tdata[VAL_W-1:0];
        got.status = m_tdata[VAL_W+STS_W-1:VAL_W];
        if (expected_results.size() == 0) report_mismatch("unexpected transfer", m_tdata, 0);
        else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) report_mismatch("value_out", got.value, want.value);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule

@@ tb/tb.sv @@
// Testbench top for the interval event window accumulator: clock, reset,
// stimulus with random idling, and the verdict. Depends on ievwa_pkg,
// the block and tb_ievwa_checker.
module tb;
  import ievwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // an action code with no operation behind it
  localparam logic [2:0] ACT_NONE = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;   // time_a, time_b, amount_in
  logic [2:0]   s_tuser = '0;   // action
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;        // value_out, status
  int           fail_count, pending;
  int           send_idle_pct = 9, recv_idle_pct = 86;
  bit           hold_recv = 1'b0;

  always #2 clk = ~clk;

  interval_event_window_accumulator i_dut (.*);
  tb_ievwa_checker i_chk (.*);

  // receiver: random stalls, or a long hold-off while hold_recv is set
  always @(posedge clk)
    m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [39:0] rand_time(bit near);
    case ($urandom_range(5))
      0: return 40'd0;
      1: return '1 - $urandom_range(3);
      2: return 40'({$urandom, $urandom});
      default: return near ? 40'($urandom_range(200)) : 40'(1000 + $urandom_range(300));
    endcase
  endfunction

  task automatic send_item(logic [2:0] act, logic [39:0] ta, logic [39:0] tb_v,
                           logic [31:0] amt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {amt, tb_v, ta};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_items(int count);
    logic [2:0] act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(9) < 4) ? ACT_ADD : 3'($urandom_range(7));
      send_item(act, rand_time($urandom_range(9) != 0), rand_time(1'b1),
                ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(8192) - 4096));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty table, extremes, fill to full, every action
    send_item(ACT_RECENT, 40'd5, 40'd0, 32'd0);
    send_item(ACT_PRUNE, 40'd5, 40'd0, 32'd0);
    send_item(ACT_SUM, 40'd10, 40'd10, 32'd0);
    send_item(ACT_SUM, 40'd20, 40'd10, 32'd0);
    send_item(ACT_ADD, '1 - 40'd2, '1, 32'h7fffffff);
    send_item(ACT_ADD, 40'd0, '1, 32'h80000000);
    send_item(ACT_ADD, 40'd0, '1, 32'h80000000);
    for (int i = 0; i < 14; i++)
      send_item(ACT_ADD, 40'(i * 3), 40'(10 + i), (i[0]) ? 32'h7fffffff : 32'h00010000);
    send_item(ACT_SUM, 40'd0, '1, 32'd0);
    send_item(ACT_SUM, 40'd0, 40'd1, 32'd0);
    send_item(ACT_RECENT, 40'd12, 40'd0, 32'd0);
    send_item(ACT_NONE, '1, '1, '1);
    send_item(ACT_EXPIRE, 40'd20, 40'd0, 32'd0);
    send_item(ACT_PRUNE, 40'd30, 40'd0, 32'd0);
    // sender pause until everything has come back
    drain();
    // receiver holds off while items keep coming
    hold_recv = 1'b1;
    fork
      begin repeat (3000) @(posedge clk); hold_recv = 1'b0; end
      random_items(20);
    join
    random_items(380);
    drain();
    send_idle_pct = 86; recv_idle_pct = 9;
    random_items(400);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(400);
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
